/* sv/uart_baud_divisor_encoder_defines.svh */
// Assertion macros used by the checker file.
`ifndef UART_BAUD_DIVISOR_ENCODER_DEFINES_SVH
`define UART_BAUD_DIVISOR_ENCODER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define UBDE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubde check failed: same-cycle rule");

// Next-cycle implication, off while in reset.
`define UBDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubde check failed: next-cycle rule");

// Next-cycle implication that also runs during reset.
`define UBDE_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ubde check failed: reset rule");

`endif

/* sv/ubde_pkg.sv */
package ubde_pkg;

  // field and datapath widths
  localparam int RATE_W = 24;
  localparam int DVD_W  = 27;  // 12 MHz * 8 fits in 27 bits
  localparam int REM_W  = RATE_W;
  localparam int NCELL  = DVD_W;  // one quotient bit per cell
  localparam int KIND_W = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int VAL_W  = 16;
  localparam int INT_W  = 14;
  localparam int DIVC_W = 17;

  localparam logic [RATE_W-1:0] MIN_RATE  = 24'd300;
  localparam logic [DVD_W-1:0]  DIV_CLAMP = 27'h1FFF8;
  localparam logic [DVD_W-1:0]  DIV_ONE   = 27'd8;

  // register index (word address bit)
  localparam logic REG_CHIP_KIND = 1'b0;

  // chip kind codes
  localparam logic [KIND_W-1:0] KIND_12MHZ  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_6MHZ_A = 3'd3;
  localparam logic [KIND_W-1:0] KIND_6MHZ_B = 3'd4;

  // word carried down the divider chain
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DVD_W-1:0]  dvd;
    logic [RATE_W-1:0] dsr;
    logic [DVD_W-1:0]  quo;
    logic              bad;
  } ubde_div_t;

  // base clock times eight
  function automatic logic [DVD_W-1:0] base_x8(input logic [KIND_W-1:0] kind);
    logic [DVD_W-1:0] r;
    case (kind)
      KIND_12MHZ:  r = 27'd96000000;
      KIND_6MHZ_A: r = 27'd48000000;
      KIND_6MHZ_B: r = 27'd48000000;
      default:     r = 27'd24000000;
    endcase
    return r;
  endfunction

  // highest legal rate: base clock / 2
  function automatic logic [RATE_W-1:0] max_rate(input logic [KIND_W-1:0] kind);
    logic [RATE_W-1:0] r;
    case (kind)
      KIND_12MHZ:  r = 24'd6000000;
      KIND_6MHZ_A: r = 24'd3000000;
      KIND_6MHZ_B: r = 24'd3000000;
      default:     r = 24'd1500000;
    endcase
    return r;
  endfunction

  // fraction (eighths) to code
  function automatic logic [2:0] frac_code(input logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd3;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd4;
      3'd4:    c = 3'd1;
      3'd5:    c = 3'd5;
      3'd6:    c = 3'd6;
      3'd7:    c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/ubde_cell.sv */
module ubde_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  ubde_pkg::ubde_div_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output ubde_pkg::ubde_div_t dn_data
);
  import ubde_pkg::*;

  logic              adv;
  logic [REM_W:0]    shifted;
  logic [REM_W+1:0]  diff;
  logic              qbit;
  ubde_div_t         step;

  // stage moves when its register is empty or drains
  assign adv      = !dn_valid || dn_ready;
  assign up_ready = adv;

  // one restoring division step
  always_comb begin
    shifted  = {up_data.rem, up_data.dvd[DVD_W-1]};
    diff     = {1'b0, shifted} - {2'b00, up_data.dsr};
    qbit     = !diff[REM_W+1];
    step     = up_data;
    step.rem = qbit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    step.dvd = {up_data.dvd[DVD_W-2:0], 1'b0};
    step.quo = {up_data.quo[DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      dn_data <= step;
    end
  end

endmodule

/* sv/ubde_enc.sv */
module ubde_enc (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  ubde_pkg::ubde_div_t up_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         divisor_value,
  output logic                divisor_index,
  output logic                status
);
  import ubde_pkg::*;

  logic              adv;
  logic [DIVC_W-1:0] div_c;
  logic [DIVC_W-1:0] enc;
  logic [VAL_W-1:0]  val_next;
  logic              idx_next;

  assign adv      = !out_valid || out_ready;
  assign up_ready = adv;

  // clamp, split and encode the quotient
  always_comb begin
    div_c = (up_data.quo > DIV_CLAMP) ? DIV_CLAMP[DIVC_W-1:0] : up_data.quo[DIVC_W-1:0];
    enc   = {frac_code(div_c[2:0]), div_c[DIVC_W-1:3]};
    if (up_data.bad || up_data.quo < DIV_ONE) begin
      val_next = '0;
      idx_next = 1'b0;
    end else if (up_data.quo == DIV_ONE) begin
      val_next = VAL_W'(1);
      idx_next = 1'b0;
    end else begin
      val_next = enc[VAL_W-1:0];
      idx_next = enc[DIVC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      divisor_value <= val_next;
      divisor_index <= idx_next;
      status        <= up_data.bad;
    end
  end

endmodule

/* sv/uart_baud_divisor_encoder.sv */
// channel  | direction | handshake           | payload
// cfg      | in        | psel/penable/pwrite | paddr, pwdata (chip_kind), prdata
// in       | in        | in_valid/in_ready   | baud_rate
// out      | out       | out_valid/out_ready | divisor_value, divisor_index, status
//
// The pipeline is 27 divider cells (one quotient bit each) and the output
// register. A new word is taken every cycle unless out_ready stalls the chain; throughput is one word per cycle.
// rst is synchronous and clears chip_kind and all valid flags.
// A stall on out_ready backs up stage by stage; empty stages keep taking words.
module uart_baud_divisor_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubde_pkg::ADDR_W-1:0]    paddr,
  input  logic [ubde_pkg::DATA_W-1:0]    pwdata,
  output logic [ubde_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ubde_pkg::RATE_W-1:0]    baud_rate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    divisor_value,
  output logic                           divisor_index,
  output logic                           status
);
  import ubde_pkg::*;

  logic [KIND_W-1:0] chip_kind;
  logic              reg_sel;
  ubde_div_t         head;
  ubde_div_t         s_data  [0:NCELL];
  logic              s_valid [0:NCELL];
  logic              s_ready [0:NCELL];

  // config register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CHIP_KIND);
  assign prdata  = reg_sel ? {{(DATA_W-KIND_W){1'b0}}, chip_kind} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_kind <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      chip_kind <= pwdata[KIND_W-1:0];
    end
  end

  // range check and divider setup
  always_comb begin
    head.rem = '0;
    head.dvd = base_x8(chip_kind);
    head.dsr = baud_rate;
    head.quo = '0;
    head.bad = (baud_rate < MIN_RATE) || (baud_rate > max_rate(chip_kind));
  end

  assign s_data[0]  = head;
  assign s_valid[0] = in_valid;
  assign in_ready   = s_ready[0];

  // divider chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ubde_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (s_valid[i]),
      .up_ready (s_ready[i]),
      .up_data  (s_data[i]),
      .dn_valid (s_valid[i+1]),
      .dn_ready (s_ready[i+1]),
      .dn_data  (s_data[i+1])
    );
  end

  // encode and output register
  ubde_enc u_enc (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (s_valid[NCELL]),
    .up_ready      (s_ready[NCELL]),
    .up_data       (s_data[NCELL]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .divisor_value (divisor_value),
    .divisor_index (divisor_index),
    .status        (status)
  );

endmodule

/* sv/ubde_chk.sv */
`include "uart_baud_divisor_encoder_defines.svh"

module ubde_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] divisor_value,
  input logic        divisor_index,
  input logic        status
);

  // reset empties the output
  `UBDE_ASSERT_NEXT_RST(a_rst_empty, rst, !out_valid)

  // a rejected rate carries zero divisor fields
  `UBDE_ASSERT_NOW(a_bad_zero, out_valid && status, divisor_value == 16'd0 && !divisor_index)

  // a legal rate gives an integer divisor of at least two
  `UBDE_ASSERT_NOW(a_ok_min, out_valid && !status, divisor_value[13:0] > 14'd1)

  // a held result stays put
  `UBDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(divisor_value) && $stable(divisor_index) && $stable(status))

endmodule

bind uart_baud_divisor_encoder ubde_chk u_ubde_chk (.*);

/* bench/uart_baud_divisor_encoder_tb.sv */
module uart_baud_divisor_encoder_tb;
  import ubde_pkg::*;

  // register addresses
  localparam logic [ADDR_W-1:0] ADDR_CHIP_KIND = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_SPARE     = 3'd4;

  // chip kinds not named in the package
  localparam logic [KIND_W-1:0] KIND_3MHZ_A  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_3MHZ_B  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam logic [31:0] MAX_EIGHTHS = 32'h1FFF8;
  localparam logic [2:0]  FRAC_TO_CODE [8] = '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7};

  localparam int IDLE_LIMIT   = 1000;
  localparam int PHASE_WORDS  = 141;
  localparam int NUM_DIRECTED = 24;

  typedef struct packed {
    logic [15:0] value;
    logic        index;
    logic        status;
  } divisor_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RATE_W-1:0] rate;
    logic              typed;
    divisor_word_t     word;
  } rate_case_t;

  typedef struct {
    logic [RATE_W-1:0] rate;
    divisor_word_t     word;
  } pending_divisor_t;

  localparam divisor_word_t RANGE_ERR = '{16'h0000, 1'b0, 1'b1};
  localparam divisor_word_t DIV_TWO   = '{16'h0002, 1'b0, 1'b0};
  localparam divisor_word_t CLAMPED   = '{16'h3FFF, 1'b0, 1'b0};
  localparam divisor_word_t NONE      = '{16'h0000, 1'b0, 1'b0};

  // directed words: typed rows carry their result, the rest go through the predictor
  localparam rate_case_t DIRECTED [NUM_DIRECTED] = '{
    '{KIND_3MHZ_A,  24'd0,        1'b1, RANGE_ERR},
    '{KIND_3MHZ_A,  24'd299,      1'b1, RANGE_ERR},
    '{KIND_3MHZ_A,  24'd300,      1'b0, NONE},
    '{KIND_3MHZ_A,  24'd9600,     1'b0, NONE},
    '{KIND_3MHZ_A,  24'd38400,    1'b0, NONE},
    '{KIND_3MHZ_A,  24'd115200,   1'b0, NONE},
    '{KIND_3MHZ_A,  24'd921600,   1'b0, NONE},
    '{KIND_3MHZ_A,  24'd1500000,  1'b1, DIV_TWO},
    '{KIND_3MHZ_A,  24'd1500001,  1'b1, RANGE_ERR},
    '{KIND_3MHZ_A,  24'hFFFFFF,   1'b1, RANGE_ERR},
    '{KIND_3MHZ_A,  24'h800000,   1'b1, RANGE_ERR},
    '{KIND_12MHZ,   24'd300,      1'b1, CLAMPED},
    '{KIND_12MHZ,   24'd732,      1'b0, NONE},
    '{KIND_12MHZ,   24'd733,      1'b0, NONE},
    '{KIND_12MHZ,   24'd1234567,  1'b0, NONE},
    '{KIND_12MHZ,   24'd6000000,  1'b1, DIV_TWO},
    '{KIND_12MHZ,   24'd6000001,  1'b1, RANGE_ERR},
    '{KIND_6MHZ_B,  24'd300,      1'b1, CLAMPED},
    '{KIND_6MHZ_B,  24'd3000000,  1'b1, DIV_TWO},
    '{KIND_6MHZ_B,  24'd3000001,  1'b1, RANGE_ERR},
    '{KIND_6MHZ_B,  24'd2999999,  1'b0, NONE},
    '{KIND_SPARE_7, 24'd1500000,  1'b1, DIV_TWO},
    '{KIND_SPARE_7, 24'd1500001,  1'b1, RANGE_ERR},
    '{KIND_SPARE_7, 24'd777777,   1'b0, NONE}
  };

  localparam logic [KIND_W-1:0] PHASE_KINDS [8] = '{KIND_12MHZ, KIND_SPARE_7, KIND_3MHZ_A,
    KIND_6MHZ_A, KIND_SPARE_5, KIND_6MHZ_B, KIND_3MHZ_B, KIND_SPARE_6};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [RATE_W-1:0] baud_rate = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       divisor_value;
  logic              divisor_index;
  logic              status;

  pending_divisor_t  pending_divisors [$];
  logic [KIND_W-1:0] kind_shadow = '0;
  int                mismatch_count = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  logic [1:0]        ready_mode = 2'd0;
  logic [7:0]        ready_cycle = '0;

  uart_baud_divisor_encoder DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .baud_rate(baud_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .divisor_value(divisor_value), .divisor_index(divisor_index), .status(status)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] base_clock_hz(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_12MHZ:               return 32'd12000000;
      KIND_6MHZ_A, KIND_6MHZ_B: return 32'd6000000;
      default:                  return 32'd3000000;
    endcase
  endfunction

  // divisor in eighths, clamped and packed with the fraction code on top
  function automatic divisor_word_t encode_divisor(input logic [RATE_W-1:0] rate,
                                                   input logic [KIND_W-1:0] kind);
    logic [31:0]   hz;
    logic [31:0]   eighths;
    logic [16:0]   packed_div;
    divisor_word_t w;
    hz = base_clock_hz(kind);
    w  = '0;
    if (rate < MIN_RATE || {8'b0, rate} > hz / 2) begin
      w.status = 1'b1;
    end else begin
      eighths = (hz * 8) / {8'b0, rate};
      if (eighths == 32'd8) begin
        w.value = 16'd1;
      end else if (eighths > 32'd8) begin
        if (eighths > MAX_EIGHTHS) eighths = MAX_EIGHTHS;
        packed_div = {FRAC_TO_CODE[eighths[2:0]], eighths[16:3]};
        w.value    = packed_div[15:0];
        w.index    = packed_div[16];
      end
    end
    return w;
  endfunction

  // mostly legal rates spread over many magnitudes, some range edges and raw noise
  function automatic logic [RATE_W-1:0] pick_rate(input logic [KIND_W-1:0] kind);
    logic [31:0]       top;
    int unsigned       sel;
    int unsigned       w;
    logic [RATE_W-1:0] r;
    top = base_clock_hz(kind) / 2;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r = RATE_W'($urandom);
    end else if (sel == 1) begin
      if ($urandom_range(0, 1) == 1) r = MIN_RATE - 24'd2 + RATE_W'($urandom_range(0, 4));
      else r = RATE_W'(top - 32'd2 + $urandom_range(0, 4));
    end else begin
      w = $urandom_range(9, RATE_W);
      r = RATE_W'($urandom & ((32'd1 << w) - 1));
      if (r < MIN_RATE || {8'b0, r} > top) r = RATE_W'($urandom_range(MIN_RATE, top));
    end
    return r;
  endfunction

  // APB write, then read back the chip kind register
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_CHIP_KIND) kind_shadow = data[KIND_W-1:0];
    pwrite <= 1'b0; penable <= 1'b0; paddr <= ADDR_CHIP_KIND;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(DATA_W-KIND_W){1'b0}}, kind_shadow}) begin
      $display("%0t chip_kind readback: expected %h, actual %h", $realtime,
               {{(DATA_W-KIND_W){1'b0}}, kind_shadow}, prdata);
      mismatch_count++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // wait until every issued rate has come back
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_divisors.size() != 0) @(posedge clk);
  endtask

  // sender bursts with random gaps
  task automatic pace_sender;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // word is taken at the edge where in_ready was high going in
  task automatic send_rate(input logic [RATE_W-1:0] rate, input divisor_word_t want);
    pending_divisor_t p;
    pace_sender();
    in_valid  <= 1'b1;
    baud_rate <= rate;
    @(posedge clk iff in_ready);
    p.rate = rate;
    p.word = want;
    pending_divisors.push_back(p);
  endtask

  // receiver: stall pattern is picked anew each time the 8-bit ready_cycle counter wraps to zero
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 8'd1;
    if (ready_cycle == 8'd0) ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ready_cycle[4];
    endcase
  end

  // result checker
  always @(posedge clk) begin : check_words
    pending_divisor_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_divisors.size() == 0) begin
        $display("%0t unexpected word: expected none, actual value=%h index=%b status=%b",
                 $realtime, divisor_value, divisor_index, status);
        mismatch_count++;
      end else begin
        want = pending_divisors.pop_front();
        if (divisor_value !== want.word.value) begin
          $display("%0t rate %0d divisor_value: expected %h, actual %h", $realtime,
                   want.rate, want.word.value, divisor_value);
          mismatch_count++;
        end
        if (divisor_index !== want.word.index) begin
          $display("%0t rate %0d divisor_index: expected %b, actual %b", $realtime,
                   want.rate, want.word.index, divisor_index);
          mismatch_count++;
        end
        if (status !== want.word.status) begin
          $display("%0t rate %0d status: expected %b, actual %b", $realtime,
                   want.rate, want.word.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a write to the spare address must leave chip_kind alone
    write_reg(ADDR_SPARE, 32'h0000_0002);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind != kind_shadow) begin
        drain_results();
        write_reg(ADDR_CHIP_KIND, {{(DATA_W-KIND_W){1'b0}}, DIRECTED[i].kind});
      end
      send_rate(DIRECTED[i].rate, DIRECTED[i].typed ? DIRECTED[i].word
                                                    : encode_divisor(DIRECTED[i].rate, kind_shadow));
    end

    // random phases, one per chip kind
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_reg(ADDR_CHIP_KIND, {$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'h0, PHASE_KINDS[ph]});
      for (int n = 0; n < PHASE_WORDS; n++) begin
        logic [RATE_W-1:0] r;
        r = pick_rate(kind_shadow);
        if (ph == 3 && n == PHASE_WORDS / 2) drain_results();
        send_rate(r, encode_divisor(r, kind_shadow));
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_divisors.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
